/* rtl/core/cfd_pkg.sv */
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 64;

    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TENT  = 2'd2;
    localparam logic [1:0] ST_PERM  = 2'd3;

    localparam logic [2:0] REQ_LOOKUP = 3'd0;
    localparam logic [2:0] REQ_ENTER  = 3'd1;
    localparam logic [2:0] REQ_CLOSE  = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_RENAME = 3'd4;
    localparam logic [2:0] REQ_FORMAT = 3'd5;

    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_NOTFOUND = 2'd1;
    localparam logic [1:0] RC_NOGAP    = 2'd2;
    localparam logic [1:0] RC_FULL     = 2'd3;

    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_TOTAL      = 2'd1;
    localparam logic [1:0] CFG_DATE       = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] name;
        logic [15:0] len;
        logic [15:0] date;
    } entry_t;

endpackage

/* rtl/core/cfd_table.sv */
`timescale 1ns / 1ps

module cfd_table #(
    parameter int ADDR_W = 6
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  cfd_pkg::entry_t       wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output cfd_pkg::entry_t       rdata
);
    import cfd_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/contiguous_file_directory_core.sv */
`timescale 1ns / 1ps

// Contiguous file directory: an ordered table of extent entries (empty,
// tentative, permanent), each with a 48-bit name, a length and a date; a
// file starts at the data start register plus the lengths of all earlier
// entries.
// One request is served at a time through a single table RAM with one
// write port and one registered read port; each table visit is a read
// state that presents the address, then a state that takes the data.
// Lookup takes a name scan; close, delete and rename take a name scan
// plus, on a hit, a tidy pass (with an extra emit step for each entry
// that follows a run of empties); enter takes a tidy pass, then a
// first-fit scan up to the hit, an upward shift of the tail above it
// and two insert writes (the new tentative entry, then the rest of the gap).
// Format and unknown requests go straight to the result state. s_ready is high only
// while no request is in progress; a finished result waits in the m_
// register while the next request is taken. Configuration writes are
// accepted whenever out of reset and take effect at once; write them only
// when idle.
// The table needs no clearing pass after reset: only entries below the
// live count are ever read.
module contiguous_file_directory_core #(
    parameter int MAX_ENTRIES = cfd_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [15:0] s_name_0,
    input  logic [15:0] s_name_1,
    input  logic [15:0] s_name_2,
    input  logic [15:0] s_new_name_0,
    input  logic [15:0] s_new_name_1,
    input  logic [15:0] s_new_name_2,
    input  logic [15:0] s_request_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_code,
    output logic [15:0] m_first_block,
    output logic [15:0] m_file_length,
    output logic [15:0] m_file_date,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cfd_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_PR   = 4'd2;
    localparam logic [3:0] S_TIDY_RD   = 4'd3;
    localparam logic [3:0] S_TIDY_PR   = 4'd4;
    localparam logic [3:0] S_TIDY_EMIT = 4'd5;
    localparam logic [3:0] S_TIDY_END  = 4'd6;
    localparam logic [3:0] S_FIT_RD    = 4'd7;
    localparam logic [3:0] S_FIT_PR    = 4'd8;
    localparam logic [3:0] S_SHIFT_RD  = 4'd9;
    localparam logic [3:0] S_SHIFT_PR  = 4'd10;
    localparam logic [3:0] S_INS0      = 4'd11;
    localparam logic [3:0] S_INS1      = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // control
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      data_start_reg, total_reg, cdate_reg;

    // request context and scan state
    logic [2:0]       req_reg, req_next;
    logic [47:0]      name_reg, name_next;
    logic [47:0]      nname_reg, nname_next;
    logic [15:0]      size_reg, size_next;
    logic [CNT_W-1:0] r_reg, r_next;       // read pointer
    logic [CNT_W-1:0] w_reg, w_next;       // compaction write pointer
    logic [CNT_W-1:0] hit_reg, hit_next;
    logic [15:0]      sum_reg, sum_next;   // running start block
    logic             old_found_reg, old_found_next;
    logic             run_reg, run_next;   // an empty run is pending
    entry_t           run_ent_reg, run_ent_next;
    logic             prev_perm_reg, prev_perm_next;
    entry_t           hold_reg, hold_next;

    // pending result and output register
    logic [1:0]       res_code_reg, res_code_next;
    logic [15:0]      res_start_reg, res_start_next;
    logic [15:0]      res_len_reg, res_len_next;
    logic [15:0]      res_date_reg, res_date_next;
    logic [1:0]       m_code_reg, m_code_next;
    logic [15:0]      m_start_reg, m_start_next;
    logic [15:0]      m_len_reg, m_len_next;
    logic [15:0]      m_date_reg, m_date_next;

    // table port
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    entry_t           tbl_wdata;
    logic [IDX_W-1:0] tbl_raddr;
    entry_t           tbl_rdata;

    cfd_table #(
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    entry_t      xf;          // entry after request edits and tent->empty
    logic        old_hit;
    logic [47:0] tgt_name;
    logic        keep_run;
    logic        want_match;
    logic [1:0]  want_status;

    // no request or register write is taken while reset is held
    assign s_ready   = aresetn && (state_reg == S_IDLE);
    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_result_code = m_code_reg;
    assign m_first_block = m_start_reg;
    assign m_file_length = m_len_reg;
    assign m_file_date   = m_date_reg;

    assign tgt_name    = (req_reg == REQ_RENAME) ? nname_reg : name_reg;
    assign want_status = (req_reg == REQ_CLOSE) ? ST_TENT : ST_PERM;
    assign want_match  = (tbl_rdata.status == want_status) && (tbl_rdata.name == name_reg);
    // a zero-length empty right after a permanent entry is dropped
    assign keep_run    = !((run_ent_reg.len == 16'd0) && prev_perm_reg);

    // request edits folded into the tidy pass
    always_comb begin
        xf      = tbl_rdata;
        old_hit = 1'b0;
        if (req_reg != REQ_ENTER) begin
            if (r_reg == hit_reg) begin
                case (req_reg)
                    REQ_DELETE: xf.status = ST_EMPTY;
                    REQ_CLOSE:  xf.status = ST_PERM;
                    REQ_RENAME: begin
                        xf.status = ST_PERM;
                        xf.name   = nname_reg;
                    end
                    default: xf = tbl_rdata;
                endcase
            end else if (!old_found_reg &&
                         (req_reg == REQ_CLOSE || req_reg == REQ_RENAME) &&
                         tbl_rdata.status == ST_PERM && tbl_rdata.name == tgt_name) begin
                xf.status = ST_EMPTY;
                old_hit   = 1'b1;
            end
        end
        if (xf.status == ST_TENT) begin
            xf.status = ST_EMPTY;
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        req_next       = req_reg;
        name_next      = name_reg;
        nname_next     = nname_reg;
        size_next      = size_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        hit_next       = hit_reg;
        sum_next       = sum_reg;
        old_found_next = old_found_reg;
        run_next       = run_reg;
        run_ent_next   = run_ent_reg;
        prev_perm_next = prev_perm_reg;
        hold_next      = hold_reg;
        res_code_next  = res_code_reg;
        res_start_next = res_start_reg;
        res_len_next   = res_len_reg;
        res_date_next  = res_date_reg;
        m_code_next    = m_code_reg;
        m_start_next   = m_start_reg;
        m_len_next     = m_len_reg;
        m_date_next    = m_date_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = w_reg[IDX_W-1:0];
        tbl_wdata      = run_ent_reg;
        tbl_raddr      = r_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next       = s_req_type;
                    name_next      = {s_name_2, s_name_1, s_name_0};
                    nname_next     = {s_new_name_2, s_new_name_1, s_new_name_0};
                    size_next      = s_request_size;
                    r_next         = '0;
                    w_next         = '0;
                    hit_next       = '0;
                    sum_next       = data_start_reg;
                    old_found_next = 1'b0;
                    run_next       = 1'b0;
                    prev_perm_next = 1'b0;
                    res_code_next  = RC_NOTFOUND;
                    res_start_next = '0;
                    res_len_next   = '0;
                    res_date_next  = '0;
                    case (s_req_type)
                        REQ_LOOKUP, REQ_CLOSE, REQ_DELETE, REQ_RENAME:
                            state_next = S_SCAN_RD;
                        REQ_ENTER:
                            state_next = S_TIDY_RD;
                        REQ_FORMAT: begin
                            tbl_we           = 1'b1;
                            tbl_waddr        = '0;
                            tbl_wdata.status = ST_EMPTY;
                            tbl_wdata.name   = '0;
                            tbl_wdata.len    = total_reg;
                            tbl_wdata.date   = '0;
                            count_next       = CNT_W'(1);
                            res_code_next    = RC_OK;
                            res_start_next   = data_start_reg;
                            res_len_next     = total_reg;
                            state_next       = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // find the first entry of the wanted status and name
            S_SCAN_RD: begin
                if (r_reg == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN_PR;
                end
            end
            S_SCAN_PR: begin
                if (want_match) begin
                    hit_next       = r_reg;
                    res_code_next  = RC_OK;
                    res_start_next = sum_reg;
                    res_len_next   = tbl_rdata.len;
                    res_date_next  = tbl_rdata.date;
                    r_next         = '0;
                    state_next     = (req_reg == REQ_LOOKUP) ? S_DONE : S_TIDY_RD;
                end else begin
                    sum_next   = sum_reg + tbl_rdata.len;
                    r_next     = r_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // in-place compaction: merge empties, drop stray zero empties
            S_TIDY_RD: begin
                state_next = (r_reg == count_reg) ? S_TIDY_END : S_TIDY_PR;
            end
            S_TIDY_PR: begin
                if (old_hit) begin
                    old_found_next = 1'b1;
                end
                if (xf.status == ST_EMPTY) begin
                    if (run_reg) begin
                        run_ent_next.len = run_ent_reg.len + xf.len;
                    end else begin
                        run_next     = 1'b1;
                        run_ent_next = xf;
                    end
                    r_next     = r_reg + CNT_W'(1);
                    state_next = S_TIDY_RD;
                end else if (run_reg) begin
                    if (keep_run) begin
                        tbl_we         = 1'b1;
                        w_next         = w_reg + CNT_W'(1);
                        prev_perm_next = 1'b0;
                    end
                    run_next   = 1'b0;
                    hold_next  = xf;
                    state_next = S_TIDY_EMIT;
                end else begin
                    tbl_we         = 1'b1;
                    tbl_wdata      = xf;
                    w_next         = w_reg + CNT_W'(1);
                    prev_perm_next = 1'b1;
                    r_next         = r_reg + CNT_W'(1);
                    state_next     = S_TIDY_RD;
                end
            end
            S_TIDY_EMIT: begin
                tbl_we         = 1'b1;
                tbl_wdata      = hold_reg;
                w_next         = w_reg + CNT_W'(1);
                prev_perm_next = 1'b1;
                r_next         = r_reg + CNT_W'(1);
                state_next     = S_TIDY_RD;
            end
            S_TIDY_END: begin
                if (run_reg && keep_run) begin
                    tbl_we     = 1'b1;
                    count_next = w_reg + CNT_W'(1);
                end else begin
                    count_next = w_reg;
                end
                run_next = 1'b0;
                r_next   = '0;
                sum_next = data_start_reg;
                state_next = (req_reg == REQ_ENTER) ? S_FIT_RD : S_DONE;
            end

            // first fit search
            S_FIT_RD: begin
                if (r_reg == count_reg) begin
                    res_code_next = RC_NOGAP;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_FIT_PR;
                end
            end
            S_FIT_PR: begin
                if (tbl_rdata.status == ST_EMPTY && size_reg <= tbl_rdata.len) begin
                    if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                        res_code_next = RC_FULL;
                        state_next    = S_DONE;
                    end else begin
                        hit_next       = r_reg;
                        hold_next      = tbl_rdata;
                        res_code_next  = RC_OK;
                        res_start_next = sum_reg;
                        res_len_next   = size_reg;
                        res_date_next  = cdate_reg;
                        r_next         = count_reg;
                        state_next     = S_SHIFT_RD;
                    end
                end else begin
                    sum_next   = sum_reg + tbl_rdata.len;
                    r_next     = r_reg + CNT_W'(1);
                    state_next = S_FIT_RD;
                end
            end

            // open a slot at the hit: move entries up one, top down
            S_SHIFT_RD: begin
                tbl_raddr = IDX_W'(r_reg - CNT_W'(1));
                state_next = (r_reg == hit_reg) ? S_INS0 : S_SHIFT_PR;
            end
            S_SHIFT_PR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_reg[IDX_W-1:0];
                tbl_wdata  = tbl_rdata;
                r_next     = r_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_INS0: begin
                tbl_we           = 1'b1;
                tbl_waddr        = hit_reg[IDX_W-1:0];
                tbl_wdata.status = ST_TENT;
                tbl_wdata.name   = name_reg;
                tbl_wdata.len    = size_reg;
                tbl_wdata.date   = cdate_reg;
                state_next       = S_INS1;
            end
            S_INS1: begin
                tbl_we        = 1'b1;
                tbl_waddr     = IDX_W'(hit_reg + CNT_W'(1));
                tbl_wdata     = hold_reg;
                tbl_wdata.len = hold_reg.len - size_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_code_next  = res_code_reg;
                    m_start_next = res_start_reg;
                    m_len_next   = res_len_reg;
                    m_date_next  = res_date_reg;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            data_start_reg <= 16'd6;
            total_reg      <= '0;
            cdate_reg      <= '0;
            run_reg        <= 1'b0;
            old_found_reg  <= 1'b0;
            prev_perm_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            run_reg       <= run_next;
            old_found_reg <= old_found_next;
            prev_perm_reg <= prev_perm_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DATA_START: data_start_reg <= cfg_data;
                    CFG_TOTAL:      total_reg      <= cfg_data;
                    CFG_DATE:       cdate_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        name_reg      <= name_next;
        nname_reg     <= nname_next;
        size_reg      <= size_next;
        r_reg         <= r_next;
        w_reg         <= w_next;
        hit_reg       <= hit_next;
        sum_reg       <= sum_next;
        run_ent_reg   <= run_ent_next;
        hold_reg      <= hold_next;
        res_code_reg  <= res_code_next;
        res_start_reg <= res_start_next;
        res_len_reg   <= res_len_next;
        res_date_reg  <= res_date_next;
        m_code_reg    <= m_code_next;
        m_start_reg   <= m_start_next;
        m_len_reg     <= m_len_next;
        m_date_reg    <= m_date_next;
    end

    // the entry count never exceeds MAX_ENTRIES
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count overflow");

    // compaction must never overtake the read pointer
    a_tidy_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TIDY_PR || state_reg == S_TIDY_EMIT) |-> w_reg <= r_reg)
        else $error("tidy write passed read");

    // an error result carries no location
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_code != RC_OK) |->
        (m_first_block == 16'd0 && m_file_length == 16'd0 && m_file_date == 16'd0))
        else $error("error result with nonzero fields");

    // an accepted request leaves idle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != S_IDLE)
        else $error("request accepted without starting");

endmodule
